FILE: hdl/itrt_pkg.sv
// ----------------------------------------------------------------------------
// itrt_pkg: shared types and constants for the radix text converter
// register indexes, fixed field widths, state codes and divider handshakes
// ----------------------------------------------------------------------------
package itrt_pkg;

	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 64;
	localparam int RADIX_W      = 6;
	localparam int DIGIT_W      = 5;
	localparam int SYM_W        = 8;
	localparam int NUM_SYM_REGS = 4;
	// quotient bits resolved per divider cycle
	localparam int DIV_BITS     = 8;

	localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYM_0_7    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYM_8_15   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SYM_16_23  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SYM_24_31  = 3'd4;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd32;

	localparam logic [SYM_W-1:0] ZERO_CHAR = 8'h30;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT,
		ST_ZERO
	} state_t;

	typedef struct packed {
		logic               start;
		logic [RADIX_W-1:0] radix;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIGIT_W-1:0] rem;
	} div_rsp_t;

endpackage

FILE: hdl/int_to_radix_text.sv
// ----------------------------------------------------------------------------
// int_to_radix_text: integer to text conversion in a configurable radix
// emits the digit symbols of one value, most significant first
// ----------------------------------------------------------------------------
// usage
//   item channel: item_valid/item_stall with value and is_signed; one transfer
//   per conversion, item_stall stays high until the last digit is read out
//   result channel: res_valid/res_stall with symbol, minus_before and last;
//   one transfer per character, last marks the final one
//   config: cfg_en/cfg_addr/cfg_data write radix and the four alphabet words
//   while no conversion is in flight
// timing
//   each digit is one long division in the divider, msb first, set by the
//   eight-bit-per-cycle long division loop; after the last digit the digit
//   memory read port is primed, then one character per cycle while res_stall is low
//   zero converts to a single '0' without using the divider
// reset and stall
//   reset clears control, radix to 10, alphabet to zero; the digit memory is
//   not cleared and needs no sweep
//   a stalled receiver holds the output register and one prefetched digit;
//   the next item is taken while the final character still waits
// ----------------------------------------------------------------------------
module int_to_radix_text #(
	parameter int MAX_DIGITS  = 64,
	parameter int VALUE_WIDTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_en,
	input  logic [itrt_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [itrt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [VALUE_WIDTH-1:0]          value,
	input  logic                            is_signed,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [itrt_pkg::SYM_W-1:0]      symbol,
	output logic                            minus_before,
	output logic                            last
);
	import itrt_pkg::*;

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);

	// configuration
	logic [RADIX_W-1:0]                       radix_q;
	logic [NUM_SYM_REGS-1:0][CFG_DATA_W-1:0] sym_q;
	logic [RADIX_W-1:0]                       eff_radix;

	// control
	state_t state_q, state_d;
	logic   accept;
	logic   neg_in;
	logic   neg_q;
	logic [VALUE_WIDTH-1:0] mag;
	logic   mag_zero;

	// divider link
	div_req_t               div_req;
	div_rsp_t               div_rsp;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic [VALUE_WIDTH-1:0] div_quot;
	logic                   quot_zero;

	// digit counting and memory
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      cnt_nxt;
	logic [CW-1:0]      n_last;
	logic               mem_we;
	logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];

	// readout
	logic [CW-1:0]      emit_left_q;
	logic [AW-1:0]      rd_idx_q;
	logic               first_q;
	logic               rd_pend_q;
	logic               rd_first_q;
	logic               rd_last_q;
	logic [DIGIT_W-1:0] rd_data_q;
	logic               rd_en;
	logic               can_load;
	logic               zero_load;
	logic               slot_free;
	logic [SYM_W-1:0]   lut_sym;

	// output register
	logic               res_valid_q;
	logic [SYM_W-1:0]   res_symbol_q;
	logic               res_minus_q;
	logic               res_last_q;

	// radix out of range is clamped to the nearest legal base
	always_comb begin
		priority if (radix_q < RADIX_MIN) begin
			eff_radix = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			eff_radix = RADIX_MAX;
		end else begin
			eff_radix = radix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
			sym_q   <= '0;
		end else if (cfg_en) begin
			unique case (cfg_addr)
				REG_RADIX:     radix_q  <= cfg_data[RADIX_W-1:0];
				REG_SYM_0_7:   sym_q[0] <= cfg_data;
				REG_SYM_8_15:  sym_q[1] <= cfg_data;
				REG_SYM_16_23: sym_q[2] <= cfg_data;
				REG_SYM_24_31: sym_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// input side: magnitude in two's complement, most negative wraps to itself
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign neg_in     = is_signed && value[VALUE_WIDTH-1];
	assign mag        = neg_in ? (~value + VALUE_WIDTH'(1)) : value;
	assign mag_zero   = (mag == '0);

	// the remaining quotient lives in the divider; restart it on each digit
	assign quot_zero     = (div_quot == '0);
	assign div_req.start = (accept && !mag_zero) || (div_rsp.done && !quot_zero);
	assign div_req.radix = eff_radix;
	assign div_dividend  = accept ? mag : div_quot;

	itrt_divider #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.rsp      (div_rsp),
		.quotient (div_quot)
	);

	// digit count saturates; digits past the limit are dropped from the top
	assign cnt_nxt = (cnt_q < CW'(MAX_DIGITS)) ? cnt_q + CW'(1) : cnt_q;
	assign n_last  = cnt_nxt - CW'(1);
	assign mem_we  = div_rsp.done && (cnt_q < CW'(MAX_DIGITS));

	// readout: one digit prefetched from memory, then into the output register
	assign slot_free = !res_valid_q || !res_stall;
	assign can_load  = (state_q == ST_EMIT) && rd_pend_q && slot_free;
	assign rd_en     = (state_q == ST_EMIT) && (emit_left_q != '0)
		&& (!rd_pend_q || can_load);
	assign zero_load = (state_q == ST_ZERO) && slot_free;
	// byte k of the alphabet word starts at bit 8k
	assign lut_sym   = sym_q[rd_data_q[DIGIT_W-1:3]][{rd_data_q[2:0], 3'b000} +: SYM_W];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = mag_zero ? ST_ZERO : ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_rsp.done && quot_zero) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if ((emit_left_q == '0) && (!rd_pend_q || can_load)) begin
					state_d = ST_IDLE;
				end
			end
			ST_ZERO: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q       <= 1'b0;
			cnt_q       <= '0;
			emit_left_q <= '0;
			rd_idx_q    <= '0;
			first_q     <= 1'b0;
			rd_pend_q   <= 1'b0;
		end else begin
			if (accept) begin
				neg_q <= neg_in;
				cnt_q <= '0;
			end
			if (div_rsp.done) begin
				cnt_q <= cnt_nxt;
				if (quot_zero) begin
					emit_left_q <= cnt_nxt;
					rd_idx_q    <= n_last[AW-1:0];
					first_q     <= 1'b1;
				end
			end
			if (rd_en) begin
				emit_left_q <= emit_left_q - CW'(1);
				rd_idx_q    <= rd_idx_q - AW'(1);
				first_q     <= 1'b0;
				rd_pend_q   <= 1'b1;
			end else if (can_load) begin
				rd_pend_q <= 1'b0;
			end
		end
	end

	// digit memory: write during division, registered read during readout
	always_ff @(posedge clk) begin
		if (mem_we) begin
			digit_mem[cnt_q[AW-1:0]] <= div_rsp.rem;
		end
		if (rd_en) begin
			rd_data_q  <= digit_mem[rd_idx_q];
			rd_first_q <= first_q;
			rd_last_q  <= (emit_left_q == CW'(1));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (can_load || zero_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			res_symbol_q <= lut_sym;
			res_minus_q  <= rd_first_q && neg_q;
			res_last_q   <= rd_last_q;
		end else if (zero_load) begin
			res_symbol_q <= ZERO_CHAR;
			res_minus_q  <= 1'b0;
			res_last_q   <= 1'b1;
		end
	end

	assign res_valid    = res_valid_q;
	assign symbol       = res_symbol_q;
	assign minus_before = res_minus_q;
	assign last         = res_last_q;

`ifndef SYNTH
	// divider results only arrive while a conversion is dividing
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider done outside division");

	// an accepted item blocks the input until its readout ends
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("input not blocked after transfer");

	// prefetched digit holds while the receiver stalls
	a_pend_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_pend_q && res_valid_q && res_stall) |=> (rd_pend_q && $stable(rd_data_q)))
		else $error("prefetched digit lost under stall");

	// readout leaves nothing behind when it ends
	a_emit_exit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) && ($past(state_q) == ST_EMIT))
			|-> (!rd_pend_q && (emit_left_q == '0)))
		else $error("readout ended with digits pending");
`endif

endmodule

FILE: hdl/itrt_divider.sv
// ----------------------------------------------------------------------------
// itrt_divider: iterative divide of a wide value by a small radix
// long division msb first, DIV_BITS quotient bits per cycle, one-cycle done pulse
// ----------------------------------------------------------------------------
module itrt_divider #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  itrt_pkg::div_req_t     req,
	input  logic [VALUE_WIDTH-1:0] dividend,
	output itrt_pkg::div_rsp_t     rsp,
	output logic [VALUE_WIDTH-1:0] quotient
);
	import itrt_pkg::*;

	localparam int STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int PAD_W = STEPS * DIV_BITS;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [PAD_W-1:0]   work_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [PAD_W-1:0]   work_nxt;
	logic [DIGIT_W-1:0] rem_nxt;

	always_comb begin : step
		logic [DIGIT_W:0]    r;
		logic [DIV_BITS-1:0] qb;
		r = {1'b0, rem_q};
		qb = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			r = {r[DIGIT_W-1:0], work_q[PAD_W-1-i]};
			if (r >= req.radix) begin
				r = r - req.radix;
				qb[DIV_BITS-1-i] = 1'b1;
			end
		end
		rem_nxt = r[DIGIT_W-1:0];
		work_nxt = (work_q << DIV_BITS) | PAD_W'(qb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= PAD_W'(dividend);
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= work_nxt;
			rem_q  <= rem_nxt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
	assign quotient = work_q[VALUE_WIDTH-1:0];

endmodule
